### rtl/core/fpp_pkg.sv
// Package for the FEN position parser: parser phases, result/error codes,
// character constants, state and result structs, and small helper functions.
// No dependencies.
package fpp_pkg;

  localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'
  localparam logic [7:0] CH_SPACE = 8'h20;  // ' '
  localparam logic [7:0] CH_W     = 8'h77;  // 'w'
  localparam logic [7:0] CH_B     = 8'h62;  // 'b'
  localparam logic [7:0] CH_UK    = 8'h4B;  // 'K'
  localparam logic [7:0] CH_UQ    = 8'h51;  // 'Q'
  localparam logic [7:0] CH_LK    = 8'h6B;  // 'k'
  localparam logic [7:0] CH_LQ    = 8'h71;  // 'q'
  localparam logic [7:0] CH_DASH  = 8'h2D;  // '-'
  localparam logic [7:0] CH_0     = 8'h30;  // '0'
  localparam logic [7:0] CH_1     = 8'h31;  // '1'
  localparam logic [7:0] CH_3     = 8'h33;  // '3'
  localparam logic [7:0] CH_6     = 8'h36;  // '6'
  localparam logic [7:0] CH_8     = 8'h38;  // '8'
  localparam logic [7:0] CH_9     = 8'h39;  // '9'
  localparam logic [7:0] CH_A     = 8'h61;  // 'a'
  localparam logic [7:0] CH_H     = 8'h68;  // 'h'

  localparam logic [15:0] SAT16 = 16'hFFFF;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 80;
  localparam int OUT_USER_W = 2;

  // bit offsets inside m_tdata
  localparam int OFS_SQUARE   = 0;
  localparam int OFS_PIECE    = 6;
  localparam int OFS_BLACK    = 10;
  localparam int OFS_CASTLE   = 11;
  localparam int OFS_EPV      = 15;
  localparam int OFS_EPSQ     = 16;
  localparam int OFS_HALF     = 22;
  localparam int OFS_FULL     = 38;
  localparam int OFS_CONSUMED = 54;
  localparam int OFS_ERROR    = 70;
  localparam int USED_DATA_W  = 73;

  typedef enum logic [1:0] {
    KIND_PIECE = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_EARLY_END = 3'd1,
    ERR_BAD_SYM   = 3'd2,
    ERR_ROW_OVF   = 3'd3,
    ERR_SEP       = 3'd4,
    ERR_COLOR     = 3'd5,
    ERR_EP_RANK   = 3'd6,
    ERR_EP_FIELD  = 3'd7
  } err_t;

  typedef enum logic [3:0] {
    PH_BOARD  = 4'd0,
    PH_SLASH  = 4'd1,
    PH_SP1    = 4'd2,
    PH_COLOR  = 4'd3,
    PH_SP2    = 4'd4,
    PH_CASTLE = 4'd5,
    PH_SP3    = 4'd6,
    PH_EP     = 4'd7,
    PH_EPRANK = 4'd8,
    PH_MSP    = 4'd9,
    PH_HFIRST = 4'd10,
    PH_HALF   = 4'd11,
    PH_FFIRST = 4'd12,
    PH_FULL   = 4'd13,
    PH_IDLE   = 4'd14
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [2:0]  cur_rank;
    logic [3:0]  cur_file;
    logic        black_side;
    logic [3:0]  castle_bits;
    logic        ep_present;
    logic [2:0]  ep_file_hold;
    logic        ep_rank6;      // 1: rank 6 (index 5), 0: rank 3 (index 2)
    logic [15:0] halfmove_hold;
    logic [15:0] fullmove_hold;
    logic [15:0] char_count;
  } pstate_t;

  localparam pstate_t ST_RESET = '{
    phase:         PH_BOARD,
    cur_rank:      3'd7,
    cur_file:      4'd0,
    black_side:    1'b0,
    castle_bits:   4'd0,
    ep_present:    1'b0,
    ep_file_hold:  3'd0,
    ep_rank6:      1'b0,
    halfmove_hold: 16'd0,
    fullmove_hold: 16'd1,
    char_count:    16'd0
  };

  typedef struct packed {
    kind_t       kind;
    logic [5:0]  square;
    logic [3:0]  piece;
    logic        black_to_move;
    logic [3:0]  castle_rights;
    logic        ep_valid;
    logic [5:0]  ep_square;
    logic [15:0] halfmove_count;
    logic [15:0] fullmove_number;
    logic [15:0] consumed_chars;
    err_t        error_code;
  } result_t;

  // piece letter lookup: {valid, index}
  function automatic logic [4:0] piece_lookup(input logic [7:0] c);
    logic [4:0] r;
    unique case (c)
      8'h50:   r = {1'b1, 4'd0};   // P
      8'h4E:   r = {1'b1, 4'd1};   // N
      8'h42:   r = {1'b1, 4'd2};   // B
      8'h52:   r = {1'b1, 4'd3};   // R
      8'h51:   r = {1'b1, 4'd4};   // Q
      8'h4B:   r = {1'b1, 4'd5};   // K
      8'h70:   r = {1'b1, 4'd6};   // p
      8'h6E:   r = {1'b1, 4'd7};   // n
      8'h62:   r = {1'b1, 4'd8};   // b
      8'h72:   r = {1'b1, 4'd9};   // r
      8'h71:   r = {1'b1, 4'd10};  // q
      8'h6B:   r = {1'b1, 4'd11};  // k
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // acc * 10 + d, saturating at 65535
  function automatic logic [15:0] add_digit(input logic [15:0] acc, input logic [3:0] d);
    logic [20:0] v;
    v = {2'b00, acc, 3'b000} + {4'b0000, acc, 1'b0} + {17'd0, d};
    return (v > {5'd0, SAT16}) ? SAT16 : v[15:0];
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v != SAT16) ? v + 16'd1 : v;
  endfunction

endpackage

### rtl/core/fpp_step.sv
// Per-character decision logic of the FEN position parser: next state and
// optional result for one transaction. Combinational. Uses fpp_pkg.
module fpp_step
  import fpp_pkg::*;
(
  input  pstate_t    st,
  input  logic [7:0] ch,
  input  logic       at_end,
  output pstate_t    st_next,
  output logic       emit,
  output result_t    res
);

  logic       dig;
  logic       dig18;
  logic [4:0] file_sum;
  logic [4:0] pc;
  logic [3:0] file_inc;
  logic [15:0] cnt_inc;
  result_t    done_res;
  result_t    err_res;
  phase_t     after_row;

  always_comb begin
    dig      = (ch >= CH_0) && (ch <= CH_9);
    dig18    = (ch >= CH_1) && (ch <= CH_8);
    file_sum = {1'b0, st.cur_file} + {1'b0, ch[3:0]};
    file_inc = st.cur_file + 4'd1;
    pc       = piece_lookup(ch);
    cnt_inc  = sat_inc(st.char_count);
    after_row = (st.cur_rank != 3'd0) ? PH_SLASH : PH_SP1;

    done_res                 = '0;
    done_res.kind            = KIND_DONE;
    done_res.black_to_move   = st.black_side;
    done_res.castle_rights   = st.castle_bits;
    done_res.ep_valid        = st.ep_present;
    done_res.ep_square       = st.ep_present ?
                               {(st.ep_rank6 ? 3'd5 : 3'd2), st.ep_file_hold} : 6'd0;
    done_res.halfmove_count  = st.halfmove_hold;
    done_res.fullmove_number = st.fullmove_hold;
    done_res.consumed_chars  = st.char_count;
    done_res.error_code      = ERR_NONE;

    err_res      = '0;
    err_res.kind = KIND_ERROR;
  end

  always_comb begin
    st_next = st;
    emit    = 1'b0;
    res     = '0;
    if (at_end) begin
      st_next = ST_RESET;
      if (st.phase >= PH_MSP && st.phase <= PH_FULL) begin
        emit = 1'b1;
        res  = done_res;
      end else if (st.phase != PH_IDLE) begin
        emit           = 1'b1;
        res            = err_res;
        res.error_code = ERR_EARLY_END;
      end
    end else begin
      unique case (st.phase)
        PH_BOARD: begin
          if (dig18) begin
            st_next.char_count = cnt_inc;
            st_next.cur_file   = file_sum[3:0];
            if (file_sum > 5'd8) begin
              emit           = 1'b1;
              res            = err_res;
              res.error_code = ERR_ROW_OVF;
              st_next.phase  = PH_IDLE;
            end else if (file_sum == 5'd8) begin
              st_next.phase = after_row;
            end
          end else if (pc[4]) begin
            emit               = 1'b1;
            res.kind           = KIND_PIECE;
            res.square         = {st.cur_rank, st.cur_file[2:0]};
            res.piece          = pc[3:0];
            st_next.cur_file   = file_inc;
            st_next.char_count = cnt_inc;
            if (file_inc == 4'd8) begin
              st_next.phase = after_row;
            end
          end else begin
            emit           = 1'b1;
            res            = err_res;
            res.error_code = ERR_BAD_SYM;
            st_next.phase  = PH_IDLE;
          end
        end
        PH_SLASH: begin
          if (ch != CH_SLASH) begin
            emit           = 1'b1;
            res            = err_res;
            res.error_code = ERR_SEP;
            st_next.phase  = PH_IDLE;
          end else begin
            st_next.char_count = cnt_inc;
            st_next.cur_rank   = st.cur_rank - 3'd1;
            st_next.cur_file   = 4'd0;
            st_next.phase      = PH_BOARD;
          end
        end
        PH_SP1, PH_SP2, PH_SP3: begin
          if (ch != CH_SPACE) begin
            emit           = 1'b1;
            res            = err_res;
            res.error_code = ERR_SEP;
            st_next.phase  = PH_IDLE;
          end else begin
            st_next.char_count = cnt_inc;
            unique case (st.phase)
              PH_SP1:  st_next.phase = PH_COLOR;
              PH_SP2:  st_next.phase = PH_CASTLE;
              default: st_next.phase = PH_EP;
            endcase
          end
        end
        PH_COLOR: begin
          if (ch == CH_B || ch == CH_W) begin
            st_next.black_side = (ch == CH_B);
            st_next.char_count = cnt_inc;
            st_next.phase      = PH_SP2;
          end else begin
            emit           = 1'b1;
            res            = err_res;
            res.error_code = ERR_COLOR;
            st_next.phase  = PH_IDLE;
          end
        end
        PH_CASTLE: begin
          st_next.char_count = cnt_inc;
          priority if (ch == CH_UK) st_next.castle_bits = st.castle_bits | 4'b0001;
          else if (ch == CH_UQ)     st_next.castle_bits = st.castle_bits | 4'b0010;
          else if (ch == CH_LK)     st_next.castle_bits = st.castle_bits | 4'b0100;
          else if (ch == CH_LQ)     st_next.castle_bits = st.castle_bits | 4'b1000;
          else if (ch == CH_DASH)   st_next.phase = PH_SP3;
          else if (ch == CH_SPACE)  st_next.phase = PH_EP;
          else begin
            emit               = 1'b1;
            res                = err_res;
            res.error_code     = ERR_SEP;
            st_next.phase      = PH_IDLE;
            st_next.char_count = st.char_count;
          end
        end
        PH_EP: begin
          if (ch >= CH_A && ch <= CH_H) begin
            st_next.ep_file_hold = ch[2:0] - 3'd1;  // 'a' is 0x61
            st_next.char_count   = cnt_inc;
            st_next.phase        = PH_EPRANK;
          end else if (ch == CH_DASH) begin
            st_next.ep_present = 1'b0;
            st_next.char_count = cnt_inc;
            st_next.phase      = PH_MSP;
          end else begin
            emit           = 1'b1;
            res            = err_res;
            res.error_code = ERR_EP_FIELD;
            st_next.phase  = PH_IDLE;
          end
        end
        PH_EPRANK: begin
          if (ch == CH_3 || ch == CH_6) begin
            st_next.ep_rank6   = (ch == CH_6);
            st_next.ep_present = 1'b1;
            st_next.char_count = cnt_inc;
            st_next.phase      = PH_MSP;
          end else begin
            emit           = 1'b1;
            res            = err_res;
            res.error_code = ERR_EP_RANK;
            st_next.phase  = PH_IDLE;
          end
        end
        PH_MSP: begin
          if (ch != CH_SPACE) begin
            emit          = 1'b1;
            res           = done_res;
            st_next.phase = PH_IDLE;
          end else begin
            st_next.char_count = cnt_inc;
            st_next.phase      = PH_HFIRST;
          end
        end
        PH_HFIRST: begin
          if (!dig) begin
            emit          = 1'b1;
            res           = done_res;
            st_next.phase = PH_IDLE;
          end else begin
            st_next.halfmove_hold = {12'd0, ch[3:0]};
            st_next.char_count    = cnt_inc;
            st_next.phase         = PH_HALF;
          end
        end
        PH_HALF: begin
          if (dig) begin
            st_next.halfmove_hold = add_digit(st.halfmove_hold, ch[3:0]);
            st_next.char_count    = cnt_inc;
          end else if (ch != CH_SPACE) begin
            emit          = 1'b1;
            res           = done_res;
            st_next.phase = PH_IDLE;
          end else begin
            st_next.char_count = cnt_inc;
            st_next.phase      = PH_FFIRST;
          end
        end
        PH_FFIRST: begin
          if (!dig) begin
            emit          = 1'b1;
            res           = done_res;
            st_next.phase = PH_IDLE;
          end else begin
            st_next.fullmove_hold = {12'd0, ch[3:0]};
            st_next.char_count    = cnt_inc;
            st_next.phase         = PH_FULL;
          end
        end
        PH_FULL: begin
          if (!dig) begin
            emit          = 1'b1;
            res           = done_res;
            st_next.phase = PH_IDLE;
          end else begin
            st_next.fullmove_hold = add_digit(st.fullmove_hold, ch[3:0]);
            st_next.char_count    = cnt_inc;
          end
        end
        default: begin
          st_next = st;
        end
      endcase
    end
  end

endmodule

### rtl/core/fpp_out_buf.sv
// Two-entry result buffer (output register plus skid stage) for the FEN
// position parser. Uses fpp_pkg.
module fpp_out_buf
  import fpp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    can_push,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    v0;
  logic    v1;
  result_t d0;
  result_t d1;
  logic    pop;

  assign pop       = v0 && out_ready;
  assign can_push  = !v1;
  assign out_valid = v0;
  assign out_data  = d0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else if (pop && v1) begin
      v0 <= 1'b1;
      v1 <= push;
    end else if (pop) begin
      v0 <= push;
    end else if (push) begin
      if (v0) begin
        v1 <= 1'b1;
      end else begin
        v0 <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && v1) begin
      d0 <= d1;
      if (push) begin
        d1 <= push_data;
      end
    end else if (pop) begin
      if (push) begin
        d0 <= push_data;
      end
    end else if (push) begin
      if (v0) begin
        d1 <= push_data;
      end else begin
        d0 <= push_data;
      end
    end
  end

endmodule

### rtl/core/fen_position_parser.sv
// FEN position parser, top level: parser state register, per-character step
// logic and the result buffer. Depends on fpp_pkg, fpp_step, fpp_out_buf.
// Results are registered in the result buffer before they show on the master side.
// Throughput: one character per cycle while s_tready is high; the state register loops
// through fpp_step. s_tready drops only while both result buffer entries are full.
// Reset (rst, synchronous): parser back to the board section, buffer emptied.
module fen_position_parser
  import fpp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] ch
  input  logic                  s_tlast,   // at_end
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // square, piece, black_to_move, castle_rights,
                                           // ep_valid, ep_square, halfmove_count,
                                           // fullmove_number, consumed_chars, error_code
  output logic [OUT_USER_W-1:0] m_tuser    // kind
);

  pstate_t st;
  pstate_t st_next;
  logic    emit;
  result_t res;
  result_t out_res;
  logic    accept;
  logic    can_push;

  assign s_tready = can_push;
  assign accept   = s_tvalid && s_tready;

  fpp_step u_step (
    .st      (st),
    .ch      (s_tdata),
    .at_end  (s_tlast),
    .st_next (st_next),
    .emit    (emit),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_RESET;
    end else if (accept) begin
      st <= st_next;
    end
  end

  fpp_out_buf u_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && emit),
    .push_data (res),
    .can_push  (can_push),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tuser = out_res.kind;
  assign m_tdata = {
    {(OUT_DATA_W - USED_DATA_W){1'b0}},
    out_res.error_code,
    out_res.consumed_chars,
    out_res.fullmove_number,
    out_res.halfmove_count,
    out_res.ep_square,
    out_res.ep_valid,
    out_res.castle_rights,
    out_res.black_to_move,
    out_res.piece,
    out_res.square
  };

endmodule

### rtl/core/fpp_checker.sv
// Port-level checks for fen_position_parser, attached by the bind below.
// Depends on fpp_pkg and fen_position_parser.
module fpp_checker
  import fpp_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic [OUT_USER_W-1:0] m_tuser
);

  a_no_result_after_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("result valid or input blocked right after reset");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == KIND_PIECE || m_tuser == KIND_DONE || m_tuser == KIND_ERROR))
    else $error("illegal result kind");

  a_piece_fields: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_PIECE) |->
      (m_tdata[OFS_PIECE+3:OFS_PIECE] <= 4'd11) &&
      (m_tdata[OUT_DATA_W-1:OFS_BLACK] == '0))
    else $error("bad piece transaction fields");

  a_error_fields: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_ERROR) |->
      (m_tdata[OFS_ERROR+2:OFS_ERROR] != ERR_NONE) &&
      (m_tdata[OFS_ERROR-1:0] == '0))
    else $error("bad error transaction fields");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind fen_position_parser fpp_checker u_fpp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
